// ===== hdl/fifoq_pkg.sv =====
// Shared types and codes for the searchable FIFO queue.
package fifoq_pkg;

  // Command codes
  localparam logic [2:0] CMD_PUSH   = 3'd0;
  localparam logic [2:0] CMD_POP    = 3'd1;
  localparam logic [2:0] CMD_PEEK   = 3'd2;
  localparam logic [2:0] CMD_CLEAR  = 3'd3;
  localparam logic [2:0] CMD_SEARCH = 3'd4;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Width of the occupancy field
  localparam int OCC_W = 5;

  typedef struct packed {
    logic [2:0]         command;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] data;
    logic               found;
    logic [OCC_W-1:0]   occupancy;
    logic               is_empty;
  } out_item_t;

  // Controls shared by every storage cell
  typedef struct packed {
    logic shift;  // take the neighbor's value (pop)
    logic cmp;    // register the compare against the search key
  } cell_ctrl_t;

endpackage

// ===== hdl/fifoq_cell.sv =====
// One storage cell of the queue chain: holds a value and compares it with a key.
module fifoq_cell (
  input  logic                  clk,
  input  logic                  rst_n,
  input  fifoq_pkg::cell_ctrl_t ctrl,
  input  logic                  load,
  input  logic                  valid,
  input  logic signed [31:0]    push_value,
  input  logic signed [31:0]    next_value,
  input  logic signed [31:0]    key,
  output logic signed [31:0]    value,
  output logic                  match
);

  logic signed [31:0] data_r;
  logic               match_r;

  // Write a pushed value, or advance from the neighbor on pop
  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= push_value;
    end else if (ctrl.shift) begin
      data_r <= next_value;
    end
  end

  // Capture the compare result for a search
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else if (ctrl.cmp) begin
      match_r <= valid && (data_r == key);
    end
  end

  assign value = data_r;
  assign match = match_r;

endmodule

// ===== hdl/fifoq_fold.sv =====
// Registered OR tree that folds the per-cell match bits eight at a time.
module fifoq_fold #(
  parameter int DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DEPTH-1:0] match,
  output logic             done,
  output logic             found
);

  localparam int STEPS = ($clog2(DEPTH) + 2) / 3;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic [DEPTH-1:0]   fold_r;
  logic [DEPTH-1:0]   src;
  logic [DEPTH-1:0]   fold_nxt;
  logic [8*DEPTH-1:0] padded;
  logic [CNT_W-1:0]   cnt_r;
  logic               busy_r;

  // Start from the cell bits, then from the last partial result
  assign src    = start ? match : fold_r;
  assign padded = {{(7*DEPTH){1'b0}}, src};

  // Reduce each group of eight bits to one
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      fold_nxt[i] = |padded[8*i +: 8];
    end
  end

  assign done  = busy_r && (cnt_r == CNT_W'(STEPS));
  assign found = fold_r[0];

  // Advance one tree level per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(1);
    end else if (done) begin
      busy_r <= 1'b0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start || (busy_r && !done)) begin
      fold_r <= fold_nxt;
    end
  end

endmodule

// ===== hdl/fifo_queue_with_search.sv =====
// Top level of the searchable FIFO queue: cell chain, control and result register.
//
// A bounded FIFO of DEPTH signed 32-bit values held in a chain of cells, oldest
// entry in the first cell. Each input item is one command (push, pop, peek,
// clear, search) and yields exactly one result item with status, data, found,
// occupancy and an empty flag. Push, pop, peek, clear and unused codes finish
// in the accepting cycle and their result is registered, so a new item can be
// taken every cycle while the result register drains. Search compares every
// cell at once and then ORs the match bits through a registered tree of
// eight-input stages, one level per cycle, so no new item is taken until the
// search result is registered. The occupancy field carries the low five bits
// of the entry count. Popping shifts every cell toward the head at once.
module fifo_queue_with_search #(
  parameter int DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  fifoq_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output fifoq_pkg::out_item_t out_data
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_FOLD = 2'd2;

  logic [1:0]            state_r, state_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic                  out_valid_r;
  fifoq_pkg::out_item_t  out_r, res;
  logic                  accept;
  logic                  empty, full;
  logic                  do_push;
  fifoq_pkg::cell_ctrl_t ctrl;
  logic signed [31:0]    cell_value [DEPTH];
  logic [DEPTH-1:0]      cell_match;
  logic                  fold_done, fold_found;
  logic [CNT_W+fifoq_pkg::OCC_W-1:0] occ_wide;
  logic [CNT_W+fifoq_pkg::OCC_W-1:0] occ_cur_wide;
  logic [fifoq_pkg::OCC_W-1:0]       occ_wide_cur;

  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;
  assign empty    = (count_r == '0);
  assign full     = (count_r == CNT_W'(DEPTH));

  assign do_push    = accept && (in_data.command == fifoq_pkg::CMD_PUSH) && !full;
  assign ctrl.shift = accept && (in_data.command == fifoq_pkg::CMD_POP) && !empty;
  assign ctrl.cmp   = accept && (in_data.command == fifoq_pkg::CMD_SEARCH);

  // Build the cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
    logic signed [31:0] next_value;
    if (i == DEPTH - 1) begin : g_last
      assign next_value = cell_value[i];
    end else begin : g_mid
      assign next_value = cell_value[i+1];
    end
    fifoq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .load       (do_push && (count_r == IDX)),
      .valid      (IDX < count_r),
      .push_value (in_data.value),
      .next_value (next_value),
      .key        (in_data.value),
      .value      (cell_value[i]),
      .match      (cell_match[i])
    );
  end

  fifoq_fold #(
    .DEPTH (DEPTH)
  ) u_fold (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == S_CMP),
    .match (cell_match),
    .done  (fold_done),
    .found (fold_found)
  );

  // Work out the next count and the immediate result
  always_comb begin
    count_nxt    = count_r;
    res.status   = fifoq_pkg::ST_OK;
    res.data     = '0;
    res.found    = 1'b0;
    case (in_data.command)
      fifoq_pkg::CMD_PUSH: begin
        if (full) begin
          res.status = fifoq_pkg::ST_FULL;
        end else begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
      fifoq_pkg::CMD_POP: begin
        if (empty) begin
          res.status = fifoq_pkg::ST_EMPTY;
        end else begin
          res.data  = cell_value[0];
          count_nxt = count_r - CNT_W'(1);
        end
      end
      fifoq_pkg::CMD_PEEK: begin
        if (empty) begin
          res.status = fifoq_pkg::ST_EMPTY;
        end else begin
          res.data = cell_value[0];
        end
      end
      fifoq_pkg::CMD_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
      end
    endcase
    occ_wide      = {{fifoq_pkg::OCC_W{1'b0}}, count_nxt};
    res.occupancy = occ_wide[fifoq_pkg::OCC_W-1:0];
    res.is_empty  = (count_nxt == '0);
  end

  // Sequence a search through compare and fold
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (ctrl.cmp) begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        state_nxt = S_FOLD;
      end
      S_FOLD: begin
        if (fold_done) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        count_r <= count_nxt;
      end
      // Hold the result until taken; load a new one when ready
      if ((accept && !ctrl.cmp) || (state_r == S_FOLD && fold_done)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Occupancy of the unchanged queue for a search result
  assign occ_cur_wide = {{fifoq_pkg::OCC_W{1'b0}}, count_r};
  assign occ_wide_cur = occ_cur_wide[fifoq_pkg::OCC_W-1:0];

  // Result payload
  always_ff @(posedge clk) begin
    if (accept && !ctrl.cmp) begin
      out_r <= res;
    end else if (state_r == S_FOLD && fold_done) begin
      out_r.status   <= fifoq_pkg::ST_OK;
      out_r.data     <= '0;
      out_r.found    <= fold_found;
      out_r.occupancy <= occ_wide_cur;
      out_r.is_empty <= empty;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
